// File: rtl/core/hrhpe_pkg.sv
// Shared types, constants and helpers for the HTTP host/path extractor.
// Holds the parser state layout, method and Host key tables, and the case fold.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrhpe_pkg;

    // Buffer sizes; stored lengths saturate at size minus one
    localparam int PATH_CAP = 256;
    localparam int HOST_CAP = 256;
    localparam logic [7:0] PATH_MAX = 8'(PATH_CAP - 1);
    localparam logic [7:0] HOST_MAX = 8'(HOST_CAP - 1);

    localparam int NUM_METHODS = 8;
    localparam int LEAD_LIMIT  = 8;

    // Byte kind codes
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_PATH  = 2'd1;
    localparam logic [1:0] KIND_HOST  = 2'd2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Request methods, lower case, trailing space included; unused slots are zero
    localparam logic [7:0] METHOD_CHARS [NUM_METHODS][LEAD_LIMIT] = '{
        '{"g", "e", "t", " ", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "o", "s", "t", " ", 8'h00, 8'h00, 8'h00},
        '{"p", "u", "t", " ", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "e", "l", "e", "t", "e", " ", 8'h00},
        '{"h", "e", "a", "d", " ", 8'h00, 8'h00, 8'h00},
        '{"o", "p", "t", "i", "o", "n", "s", " "},
        '{"c", "o", "n", "n", "e", "c", "t", " "},
        '{"p", "a", "t", "c", "h", " ", 8'h00, 8'h00}
    };
    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd4, 4'd5, 4'd4, 4'd7, 4'd5, 4'd8, 4'd8, 4'd6
    };

    // "\r\nHost:" in lower case; last slot is never reached
    localparam int HOST_KEY_LEN = 7;
    localparam logic [7:0] HOST_KEY [8] = '{
        8'h0d, 8'h0a, "h", "o", "s", "t", ":", 8'h00
    };

    typedef enum logic [2:0] {
        URL_BEFORE = 3'b001,
        URL_IN     = 3'b010,
        URL_AFTER  = 3'b100
    } url_phase_t;

    typedef enum logic [3:0] {
        HOST_SEARCH = 4'b0001,
        HOST_SKIP   = 4'b0010,
        HOST_IN     = 4'b0100,
        HOST_CLOSED = 4'b1000
    } host_phase_t;

    typedef struct packed {
        logic [3:0]  lead_count;
        logic [7:0]  method_alive;
        url_phase_t  url_phase;
        logic [7:0]  path_count;
        logic        path_before_crlf;
        logic        crlf_seen;
        logic        prev_was_cr;
        logic [2:0]  host_match_step;
        host_phase_t host_phase;
        logic [7:0]  host_count;
        logic        zero_seen;
    } state_t;

    localparam state_t STATE_RESET = '{
        lead_count:       4'd0,
        method_alive:     8'hff,
        url_phase:        URL_BEFORE,
        path_count:       8'd0,
        path_before_crlf: 1'b0,
        crlf_seen:        1'b0,
        prev_was_cr:      1'b0,
        host_match_step:  3'd0,
        host_phase:       HOST_SEARCH,
        host_count:       8'd0,
        zero_seen:        1'b0
    };

    typedef struct packed {
        logic [1:0] byte_kind;
        logic [7:0] byte_position;
        logic       method_found;
        logic       path_ok;
        logic [7:0] path_len;
        logic       host_ok;
        logic [7:0] host_len;
    } result_t;

    // ASCII upper to lower case
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z")
            r = c + 8'd32;
        return r;
    endfunction

    // Some still-alive method has been matched in full
    function automatic logic method_hit(input logic [7:0] alive, input logic [3:0] lead);
        logic hit;
        hit = 1'b0;
        for (int m = 0; m < NUM_METHODS; m++)
            if (alive[m] && lead >= METHOD_LEN[m])
                hit = 1'b1;
        return hit;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/hrhpe_step.sv
// Per-byte parser step: next parser state and tag for one payload byte.
// Pure combinational logic; depends on hrhpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrhpe_step (
    input  hrhpe_pkg::state_t  st,
    input  logic [7:0]         byte_value,
    input  logic               last_byte,
    output hrhpe_pkg::state_t  st_next,
    output hrhpe_pkg::result_t res
);

    always_comb
    begin
        hrhpe_pkg::state_t s;
        logic [7:0] fb;
        logic       path_cand;
        logic       host_cand;
        logic       found;
        logic [1:0] kind;
        logic [7:0] pos;

        s         = st;
        fb        = hrhpe_pkg::fold(byte_value);
        path_cand = 1'b0;
        host_cand = 1'b0;
        kind      = hrhpe_pkg::KIND_OTHER;
        pos       = 8'd0;

        if (!s.zero_seen)
        begin
            // method matching over the leading bytes
            if (s.lead_count < 4'(hrhpe_pkg::LEAD_LIMIT))
            begin
                for (int m = 0; m < hrhpe_pkg::NUM_METHODS; m++)
                    if (s.method_alive[m] && s.lead_count < hrhpe_pkg::METHOD_LEN[m] &&
                        fb != hrhpe_pkg::METHOD_CHARS[m][s.lead_count[2:0]])
                        s.method_alive[m] = 1'b0;
                s.lead_count = s.lead_count + 4'd1;
            end

            if (byte_value == hrhpe_pkg::CHAR_NUL)
            begin
                s.zero_seen = 1'b1;
            end
            else
            begin
                // request line: path lies between first and second space
                unique case (s.url_phase)
                    hrhpe_pkg::URL_BEFORE:
                    begin
                        if (byte_value == hrhpe_pkg::CHAR_SPACE)
                            s.url_phase = hrhpe_pkg::URL_IN;
                    end
                    hrhpe_pkg::URL_IN:
                    begin
                        if (byte_value == hrhpe_pkg::CHAR_SPACE)
                        begin
                            s.url_phase        = hrhpe_pkg::URL_AFTER;
                            s.path_before_crlf = !s.crlf_seen;
                        end
                        else
                        begin
                            path_cand = 1'b1;
                        end
                    end
                    hrhpe_pkg::URL_AFTER:
                    begin
                    end
                    default:
                    begin
                    end
                endcase

                // first CRLF
                if (byte_value == hrhpe_pkg::CHAR_LF && s.prev_was_cr)
                    s.crlf_seen = 1'b1;
                s.prev_was_cr = (byte_value == hrhpe_pkg::CHAR_CR);

                // Host header search and field capture
                unique case (s.host_phase)
                    hrhpe_pkg::HOST_SEARCH:
                    begin
                        if (fb == hrhpe_pkg::HOST_KEY[s.host_match_step])
                        begin
                            if (s.host_match_step == 3'(hrhpe_pkg::HOST_KEY_LEN - 1))
                            begin
                                s.host_match_step = 3'd0;
                                s.host_phase      = hrhpe_pkg::HOST_SKIP;
                            end
                            else
                            begin
                                s.host_match_step = s.host_match_step + 3'd1;
                            end
                        end
                        else
                        begin
                            // a CR restarts the key one step in
                            s.host_match_step = (byte_value == hrhpe_pkg::CHAR_CR) ? 3'd1 : 3'd0;
                        end
                    end
                    hrhpe_pkg::HOST_SKIP:
                    begin
                        s.host_phase = hrhpe_pkg::HOST_IN;
                    end
                    hrhpe_pkg::HOST_IN:
                    begin
                        if (byte_value == hrhpe_pkg::CHAR_CR)
                            s.host_phase = hrhpe_pkg::HOST_CLOSED;
                        else
                            host_cand = 1'b1;
                    end
                    hrhpe_pkg::HOST_CLOSED:
                    begin
                    end
                    default:
                    begin
                    end
                endcase

                // tag; host wins over path on overlap
                found = hrhpe_pkg::method_hit(s.method_alive, s.lead_count);
                if (found && host_cand)
                begin
                    if (s.host_count < hrhpe_pkg::HOST_MAX)
                    begin
                        kind         = hrhpe_pkg::KIND_HOST;
                        pos          = s.host_count;
                        s.host_count = s.host_count + 8'd1;
                    end
                end
                else if (found && path_cand)
                begin
                    if (s.path_count < hrhpe_pkg::PATH_MAX)
                    begin
                        kind         = hrhpe_pkg::KIND_PATH;
                        pos          = s.path_count;
                        s.path_count = s.path_count + 8'd1;
                    end
                end
            end
        end

        // result from the updated state
        found             = hrhpe_pkg::method_hit(s.method_alive, s.lead_count);
        res.byte_kind     = kind;
        res.byte_position = pos;
        res.method_found  = found;
        res.path_ok       = found && s.path_before_crlf && s.crlf_seen;
        res.path_len      = s.path_count;
        res.host_ok       = found && (s.host_phase == hrhpe_pkg::HOST_CLOSED);
        res.host_len      = s.host_count;

        // packet end returns the parser to its reset state
        st_next = last_byte ? hrhpe_pkg::STATE_RESET : s;
    end

endmodule

`default_nettype wire

// File: rtl/core/http_request_host_path_extractor_top.sv
// Top level of the HTTP request-line / Host-header byte tagger.
// Input register, parser step (hrhpe_step), result register; uses hrhpe_pkg.
// Throughput: one byte per cycle while out_stall is low; the parser state feeds back through its own register.
// Reset: rst_n clears both valid flags and returns the parser state to start-of-packet.
`timescale 1ns / 1ps
`default_nettype none

module http_request_host_path_extractor_top (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] byte_kind,
    output logic [7:0] byte_position,
    output logic       packet_done,
    output logic       method_found,
    output logic       path_ok,
    output logic [7:0] path_len,
    output logic       host_ok,
    output logic [7:0] host_len
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    hrhpe_pkg::state_t  state_reg;
    hrhpe_pkg::state_t  state_next;
    hrhpe_pkg::result_t res_next;
    hrhpe_pkg::result_t res_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               advance;

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= byte_value;
            in_last_reg <= last_byte;
        end
    end

    // parser step
    hrhpe_step u_step (
        .st         (state_reg),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .st_next    (state_next),
        .res        (res_next)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hrhpe_pkg::STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg      <= res_next;
            out_byte_reg <= in_byte_reg;
            out_last_reg <= in_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign packet_done   = out_last_reg;
    assign byte_kind     = res_reg.byte_kind;
    assign byte_position = res_reg.byte_position;
    assign method_found  = res_reg.method_found;
    assign path_ok       = res_reg.path_ok;
    assign path_len      = res_reg.path_len;
    assign host_ok       = res_reg.host_ok;
    assign host_len      = res_reg.host_len;

endmodule

`default_nettype wire

// File: rtl/core/hrhpe_checker.sv
// Port-level checks for the HTTP host/path extractor, bound to its top level.
// Depends on hrhpe_pkg for the byte kind codes.
`timescale 1ns / 1ps
`default_nettype none

module hrhpe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] byte_value,
    input logic       last_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [1:0] byte_kind,
    input logic [7:0] byte_position,
    input logic       packet_done,
    input logic       method_found,
    input logic       path_ok,
    input logic [7:0] path_len,
    input logic       host_ok,
    input logic [7:0] host_len
);

    // a stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(byte_kind))
        else $error("stalled result changed");

    // only a matched method lets bytes be tagged or fields be reported good
    a_tag_needs_method: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_kind != hrhpe_pkg::KIND_OTHER || path_ok || host_ok)
        |-> method_found)
        else $error("tag or ok without a method");

    // a tagged path byte's slot is the last counted one
    a_path_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_kind == hrhpe_pkg::KIND_PATH |-> path_len == byte_position + 8'd1)
        else $error("path position and length disagree");

    // a tagged host byte's slot is the last counted one
    a_host_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_kind == hrhpe_pkg::KIND_HOST |-> host_len == byte_position + 8'd1)
        else $error("host position and length disagree");

    // untagged bytes carry position zero, and no undefined kind appears
    a_other_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_kind == hrhpe_pkg::KIND_OTHER && byte_position == 8'd0) ||
                      byte_kind == hrhpe_pkg::KIND_PATH || byte_kind == hrhpe_pkg::KIND_HOST)
        else $error("bad kind or position");

endmodule

bind http_request_host_path_extractor_top hrhpe_checker u_hrhpe_checker (.*);

`default_nettype wire
